>>> src/bpp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpp_pkg: shared types, constants and fixed-point helpers
// Q-format word types, transaction structs, register indexes and the
// rounding / saturating arithmetic used by the setup unit and the datapath.
// ----------------------------------------------------------------------------
package bpp_pkg;

	localparam int WORD_W        = 32;
	localparam int FRAC_BITS_DEF = 16;
	localparam int QDEPTH        = 4;
	localparam int CFG_IDX_W     = 4;
	localparam int DT_W          = WORD_W - 1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_E_X    = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_E_Y    = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_E_Z    = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_B_X    = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_B_Y    = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_B_Z    = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_DT     = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_CHARGE = 4'd7;

	localparam logic [DT_W-1:0] DT_RESET = 31'd655;

	typedef logic signed [WORD_W-1:0]   word_t;
	typedef logic signed [2*WORD_W-1:0] prod_t;
	typedef logic signed [2*WORD_W+1:0] wide_t;

	localparam word_t WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
	localparam word_t WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
	localparam wide_t WIDE_MAX = {{(WORD_W+3){1'b0}}, {(WORD_W-1){1'b1}}};
	localparam wide_t WIDE_MIN = {{(WORD_W+3){1'b1}}, {(WORD_W-1){1'b0}}};
	localparam wide_t WIDE_ONE = {{(2*WORD_W+1){1'b0}}, 1'b1};

	typedef struct packed {
		word_t vel_x_in;
		word_t vel_y_in;
		word_t vel_z_in;
		word_t pos_x_in;
		word_t pos_y_in;
		word_t pos_z_in;
	} particle_t;

	typedef struct packed {
		word_t vel_x_out;
		word_t vel_y_out;
		word_t vel_z_out;
		word_t pos_x_out;
		word_t pos_y_out;
		word_t pos_z_out;
	} result_t;

	// queue entry: half-kicked velocity and untouched position
	typedef struct packed {
		word_t [2:0] vm;
		word_t [2:0] pos;
	} qitem_t;

	// per-configuration coefficients
	typedef struct packed {
		word_t [2:0] kick;
		word_t [2:0] t;
		word_t [2:0] s;
		word_t       dt;
	} coef_t;

	function automatic word_t sat_wide(wide_t x);
		if (x > WIDE_MAX)
			return WORD_MAX;
		else if (x < WIDE_MIN)
			return WORD_MIN;
		else
			return x[WORD_W-1:0];
	endfunction

	// round to nearest, ties away from zero, then saturate
	function automatic word_t rnd_sat(prod_t p, int sh);
		wide_t x;
		wide_t half;
		x = {{2{p[2*WORD_W-1]}}, p};
		half = WIDE_ONE << (sh - 1);
		if (p[2*WORD_W-1])
			x = x + half - WIDE_ONE;
		else
			x = x + half;
		x = x >>> sh;
		return sat_wide(x);
	endfunction

	function automatic word_t sadd(word_t a, word_t b);
		logic signed [WORD_W:0] s;
		s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
		if (s[WORD_W] != s[WORD_W-1])
			return s[WORD_W] ? WORD_MIN : WORD_MAX;
		return s[WORD_W-1:0];
	endfunction

	function automatic word_t ssub(word_t a, word_t b);
		logic signed [WORD_W:0] s;
		s = {a[WORD_W-1], a} - {b[WORD_W-1], b};
		if (s[WORD_W] != s[WORD_W-1])
			return s[WORD_W] ? WORD_MIN : WORD_MAX;
		return s[WORD_W-1:0];
	endfunction

	// +1.0 in the chosen format, clamped
	function automatic word_t one_sat(int f);
		if (f >= WORD_W - 1)
			return WORD_MAX;
		return word_t'(WIDE_ONE << f);
	endfunction

	// -1.0 in the chosen format, clamped
	function automatic word_t neg_one_sat(int f);
		if (f >= WORD_W - 1)
			return WORD_MIN;
		return -word_t'(WIDE_ONE << f);
	endfunction

endpackage
`default_nettype wire

>>> src/bpp_setup.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpp_setup: configuration registers and coefficient sequencer
// Holds the field, charge and time-step registers and, after reset or any
// write, derives kick, t and s with one shared multiplier and a divider.
// ----------------------------------------------------------------------------
module bpp_setup #(
	parameter int FRAC_BITS = bpp_pkg::FRAC_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_wr,
	input  wire logic [bpp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [bpp_pkg::WORD_W-1:0]     cfg_data,
	output bpp_pkg::coef_t                      coef,
	output logic                                busy
);
	localparam int W   = bpp_pkg::WORD_W;
	localparam int QW  = 2*FRAC_BITS + 2;   // quotient bits
	localparam int CW  = $clog2(QW);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_RND  = 2'd3;

	// step ranges of the multiply program
	localparam logic [4:0] S_QE   = 5'd0;
	localparam logic [4:0] S_QB   = 5'd3;
	localparam logic [4:0] S_KICK = 5'd6;
	localparam logic [4:0] S_T    = 5'd9;
	localparam logic [4:0] S_TT   = 5'd12;
	localparam logic [4:0] S_S    = 5'd15;
	localparam logic [4:0] S_TT_LAST = 5'd14;
	localparam logic [4:0] S_LAST    = 5'd17;

	bpp_pkg::word_t        e_q [3];
	bpp_pkg::word_t        b_q [3];
	logic [bpp_pkg::DT_W-1:0] dt_q;
	bpp_pkg::word_t        chg_q;

	logic [1:0]            st_q;
	logic [4:0]            step_q;
	logic                  ph_q;
	bpp_pkg::prod_t        prod_q;
	bpp_pkg::word_t        qe_q [3];
	bpp_pkg::word_t        qb_q [3];
	bpp_pkg::word_t        kick_q [3];
	bpp_pkg::word_t        t_q [3];
	bpp_pkg::word_t        s_q [3];
	bpp_pkg::word_t        tt_q;
	bpp_pkg::word_t        den_q;
	bpp_pkg::word_t        sf_q;
	logic [W:0]            rem_q;
	logic [QW:0]           quo_q;
	logic [CW-1:0]         cnt_q;

	bpp_pkg::word_t        dtw;
	bpp_pkg::word_t        op_a, op_b, rnd, tt_nx, den_nx;
	logic [1:0]            idx;
	int                    sh;
	logic [W:0]            r2;
	logic [QW:0]           qr;
	logic                  qsat;

	assign dtw  = {1'b0, dt_q};
	assign busy = (st_q != ST_IDLE);

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				e_q[i] <= '0;
			end
			b_q[0] <= '0;
			b_q[1] <= '0;
			b_q[2] <= bpp_pkg::neg_one_sat(FRAC_BITS);
			dt_q   <= bpp_pkg::DT_RESET;
			chg_q  <= bpp_pkg::neg_one_sat(FRAC_BITS);
		end else if (cfg_wr) begin
			unique case (cfg_index)
				bpp_pkg::REG_E_X:    e_q[0] <= cfg_data;
				bpp_pkg::REG_E_Y:    e_q[1] <= cfg_data;
				bpp_pkg::REG_E_Z:    e_q[2] <= cfg_data;
				bpp_pkg::REG_B_X:    b_q[0] <= cfg_data;
				bpp_pkg::REG_B_Y:    b_q[1] <= cfg_data;
				bpp_pkg::REG_B_Z:    b_q[2] <= cfg_data;
				bpp_pkg::REG_DT:     dt_q   <= cfg_data[bpp_pkg::DT_W-1:0];
				bpp_pkg::REG_CHARGE: chg_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// operand select for the shared multiplier
	always_comb begin
		op_a = chg_q;
		op_b = e_q[0];
		sh   = FRAC_BITS;
		idx  = 2'(step_q - S_QE);
		priority if (step_q < S_QB) begin
			idx = 2'(step_q - S_QE);
			op_b = e_q[idx];
		end else if (step_q < S_KICK) begin
			idx = 2'(step_q - S_QB);
			op_b = b_q[idx];
		end else if (step_q < S_T) begin
			idx = 2'(step_q - S_KICK);
			op_a = qe_q[idx]; op_b = dtw; sh = FRAC_BITS + 1;
		end else if (step_q < S_TT) begin
			idx = 2'(step_q - S_T);
			op_a = qb_q[idx]; op_b = dtw; sh = FRAC_BITS + 1;
		end else if (step_q < S_S) begin
			idx = 2'(step_q - S_TT);
			op_a = t_q[idx]; op_b = t_q[idx];
		end else begin
			idx = 2'(step_q - S_S);
			op_a = sf_q; op_b = t_q[idx];
		end
		rnd    = bpp_pkg::rnd_sat(prod_q, sh);
		tt_nx  = (step_q == S_TT) ? rnd : bpp_pkg::sadd(tt_q, rnd);
		den_nx = bpp_pkg::sadd(bpp_pkg::one_sat(FRAC_BITS), tt_nx);
		// restoring division step: numerator is 2^(2F+1)
		r2 = {rem_q[W-1:0], (cnt_q == CW'(2*FRAC_BITS + 1))};
		qr = quo_q + (QW+1)'(1);
		if ({rem_q[W-1:0], 1'b0} < {1'b0, den_q})
			qr = quo_q;
		qsat = 1'b0;
		for (int b = W - 1; b <= QW; b++) begin
			qsat = qsat | qr[b];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_MUL;
			step_q <= S_QE;
			ph_q   <= 1'b0;
		end else if (cfg_wr) begin
			st_q   <= ST_MUL;
			step_q <= S_QE;
			ph_q   <= 1'b0;
		end else begin
			unique case (st_q)
				ST_MUL: begin
					ph_q <= ~ph_q;
					if (ph_q) begin
						step_q <= step_q + 5'd1;
						if (step_q == S_TT_LAST)
							st_q <= ST_DIV;
						else if (step_q == S_LAST)
							st_q <= ST_IDLE;
					end
				end
				ST_DIV: begin
					if (cnt_q == '0)
						st_q <= ST_RND;
				end
				ST_RND: st_q <= ST_MUL;
				ST_IDLE: ;
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (st_q == ST_MUL && !ph_q)
			prod_q <= op_a * op_b;
		if (st_q == ST_MUL && ph_q) begin
			priority if (step_q < S_QB) begin
				qe_q[idx] <= rnd;
			end else if (step_q < S_KICK) begin
				qb_q[idx] <= rnd;
			end else if (step_q < S_T) begin
				kick_q[idx] <= rnd;
			end else if (step_q < S_TT) begin
				t_q[idx] <= rnd;
			end else if (step_q < S_S) begin
				tt_q <= tt_nx;
				if (step_q == S_TT_LAST) begin
					den_q <= (den_nx < bpp_pkg::word_t'(1)) ? bpp_pkg::word_t'(1) : den_nx;
					rem_q <= '0;
					quo_q <= '0;
					cnt_q <= CW'(QW - 1);
				end
			end else begin
				s_q[idx] <= rnd;
			end
		end
		if (st_q == ST_DIV) begin
			if (r2 >= {1'b0, den_q}) begin
				rem_q <= r2 - {1'b0, den_q};
				quo_q <= {quo_q[QW-1:0], 1'b1};
			end else begin
				rem_q <= r2;
				quo_q <= {quo_q[QW-1:0], 1'b0};
			end
			cnt_q <= cnt_q - CW'(1);
		end
		if (st_q == ST_RND)
			sf_q <= qsat ? bpp_pkg::WORD_MAX : W'(qr);
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			coef.kick[i] = kick_q[i];
			coef.t[i]    = t_q[i];
			coef.s[i]    = s_q[i];
		end
		coef.dt = dtw;
	end

endmodule
`default_nettype wire

>>> src/bpp_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpp_front: input stage
// Accepts a particle, applies the first half kick and hands it to the queue.
// ----------------------------------------------------------------------------
module bpp_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  bpp_pkg::particle_t  in_data,
	input  wire logic           busy,
	input  bpp_pkg::coef_t      coef,
	input  wire logic           q_full,
	output logic                q_push,
	output bpp_pkg::qitem_t     q_data
);
	logic            v_s1;
	bpp_pkg::qitem_t d_s1;
	logic            acc;

	assign q_push   = v_s1 && !q_full;
	assign in_ready = !busy && (!v_s1 || !q_full);
	assign acc      = in_valid && in_ready;
	assign q_data   = d_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else
			v_s1 <= acc || (v_s1 && !q_push);
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			d_s1.vm[0]  <= bpp_pkg::sadd(in_data.vel_x_in, coef.kick[0]);
			d_s1.vm[1]  <= bpp_pkg::sadd(in_data.vel_y_in, coef.kick[1]);
			d_s1.vm[2]  <= bpp_pkg::sadd(in_data.vel_z_in, coef.kick[2]);
			d_s1.pos[0] <= in_data.pos_x_in;
			d_s1.pos[1] <= in_data.pos_y_in;
			d_s1.pos[2] <= in_data.pos_z_in;
		end
	end

endmodule
`default_nettype wire

>>> src/bpp_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpp_queue: small FIFO between front and back
// Register-based queue; simultaneous push and pop allowed.
// ----------------------------------------------------------------------------
module bpp_queue (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  bpp_pkg::qitem_t wdata,
	output logic            full,
	input  wire logic       pop,
	output logic            empty,
	output bpp_pkg::qitem_t rdata
);
	localparam int AW = $clog2(bpp_pkg::QDEPTH);

	bpp_pkg::qitem_t mem [bpp_pkg::QDEPTH];
	logic [AW-1:0]   wp_q, rp_q;
	logic [AW:0]     cnt_q;

	assign full  = (cnt_q == (AW+1)'(bpp_pkg::QDEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= wp_q + AW'(1);
			if (pop)
				rp_q <= rp_q + AW'(1);
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem[wp_q] <= wdata;
	end

endmodule
`default_nettype wire

>>> src/bpp_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpp_back: rotation, second kick and position update pipeline
// Eight stages; the last is the output register. Whole pipe stalls together.
// ----------------------------------------------------------------------------
module bpp_back #(
	parameter int FRAC_BITS = bpp_pkg::FRAC_BITS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          q_empty,
	input  bpp_pkg::qitem_t    q_data,
	output logic               q_pop,
	input  bpp_pkg::coef_t     coef,
	output logic               out_valid,
	input  wire logic          out_ready,
	output bpp_pkg::result_t   out_data
);
	logic [8:1]     v;
	logic           en;

	bpp_pkg::word_t vm_s1 [3], p_s1 [3];
	bpp_pkg::prod_t pa_s2 [3], pb_s2 [3];
	bpp_pkg::word_t vm_s2 [3], p_s2 [3];
	bpp_pkg::word_t vq_s3 [3], vm_s3 [3], p_s3 [3];
	bpp_pkg::prod_t pa_s4 [3], pb_s4 [3];
	bpp_pkg::word_t vm_s4 [3], p_s4 [3];
	bpp_pkg::word_t vp_s5 [3], p_s5 [3];
	bpp_pkg::word_t vn_s6 [3], p_s6 [3];
	bpp_pkg::prod_t pd_s7 [3];
	bpp_pkg::word_t vn_s7 [3], p_s7 [3];
	bpp_pkg::word_t vn_s8 [3], p_s8 [3];

	assign en        = !(v[8] && !out_ready);
	assign q_pop     = en && !q_empty;
	assign out_valid = v[8];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v <= '0;
		else if (en)
			v <= {v[7:1], !q_empty};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				vm_s1[i] <= q_data.vm[i];
				p_s1[i]  <= q_data.pos[i];
				// v' = v- + v- x t
				pa_s2[i] <= vm_s1[(i+1)%3] * coef.t[(i+2)%3];
				pb_s2[i] <= vm_s1[(i+2)%3] * coef.t[(i+1)%3];
				vm_s2[i] <= vm_s1[i];
				p_s2[i]  <= p_s1[i];
				vq_s3[i] <= bpp_pkg::ssub(
					bpp_pkg::sadd(vm_s2[i], bpp_pkg::rnd_sat(pa_s2[i], FRAC_BITS)),
					bpp_pkg::rnd_sat(pb_s2[i], FRAC_BITS));
				vm_s3[i] <= vm_s2[i];
				p_s3[i]  <= p_s2[i];
				// v+ = v- + v' x s
				pa_s4[i] <= vq_s3[(i+1)%3] * coef.s[(i+2)%3];
				pb_s4[i] <= vq_s3[(i+2)%3] * coef.s[(i+1)%3];
				vm_s4[i] <= vm_s3[i];
				p_s4[i]  <= p_s3[i];
				vp_s5[i] <= bpp_pkg::ssub(
					bpp_pkg::sadd(vm_s4[i], bpp_pkg::rnd_sat(pa_s4[i], FRAC_BITS)),
					bpp_pkg::rnd_sat(pb_s4[i], FRAC_BITS));
				p_s5[i]  <= p_s4[i];
				vn_s6[i] <= bpp_pkg::sadd(vp_s5[i], coef.kick[i]);
				p_s6[i]  <= p_s5[i];
				pd_s7[i] <= vn_s6[i] * coef.dt;
				vn_s7[i] <= vn_s6[i];
				p_s7[i]  <= p_s6[i];
				vn_s8[i] <= vn_s7[i];
				p_s8[i]  <= bpp_pkg::sadd(p_s7[i], bpp_pkg::rnd_sat(pd_s7[i], FRAC_BITS));
			end
		end
	end

	assign out_data.vel_x_out = vn_s8[0];
	assign out_data.vel_y_out = vn_s8[1];
	assign out_data.vel_z_out = vn_s8[2];
	assign out_data.pos_x_out = p_s8[0];
	assign out_data.pos_y_out = p_s8[1];
	assign out_data.pos_z_out = p_s8[2];

endmodule
`default_nettype wire

>>> src/boris_particle_push.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// boris_particle_push: Boris particle pusher, one particle per transaction
// Half E kick, magnetic rotation, half E kick, position update, all in
// saturating fixed point with round-to-nearest products.
//
//  channel   | signals                               | role
//  ----------+---------------------------------------+--------------------
//  particle  | particle_valid/ready, particle        | velocity + position in
//  result    | result_valid/ready, result            | updated particle out
//  cfg       | cfg_valid/ready, cfg_index, cfg_data  | register writes
//
// Throughput: one particle per cycle while the coefficient sequencer is idle
// and results are taken. An accepted particle passes the front stage, the
// queue and the eight-stage back pipe before result_valid rises. After reset
// and after every cfg transaction the coefficient sequencer runs 18 multiply
// steps, 2*FRAC_BITS+2 bit-serial divider steps and one rounding step;
// particle_ready is low meanwhile. cfg_ready is always high.
// A stalled result freezes the back pipe; the 4-entry queue and front stage
// keep accepting until they fill.
// ----------------------------------------------------------------------------
module boris_particle_push #(
	parameter int FRAC_BITS = bpp_pkg::FRAC_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           particle_valid,
	output logic                                particle_ready,
	input  bpp_pkg::particle_t                  particle,
	output logic                                result_valid,
	input  wire logic                           result_ready,
	output bpp_pkg::result_t                    result,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [bpp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [bpp_pkg::WORD_W-1:0]     cfg_data
);
	bpp_pkg::coef_t  coef;
	logic            busy;
	logic            q_full, q_empty, q_push, q_pop;
	bpp_pkg::qitem_t q_wdata, q_rdata;

	assign cfg_ready = 1'b1;

	// registers and per-configuration coefficients
	bpp_setup #(.FRAC_BITS(FRAC_BITS)) u_setup (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.coef      (coef),
		.busy      (busy)
	);

	// accept + first half kick
	bpp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (particle_valid),
		.in_ready (particle_ready),
		.in_data  (particle),
		.busy     (busy),
		.coef     (coef),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_data   (q_wdata)
	);

	// decouples front from back
	bpp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.empty  (q_empty),
		.rdata  (q_rdata)
	);

	// rotation, second kick, position
	bpp_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_data    (q_rdata),
		.q_pop     (q_pop),
		.coef      (coef),
		.out_valid (result_valid),
		.out_ready (result_ready),
		.out_data  (result)
	);

endmodule
`default_nettype wire

>>> src/bpp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpp_checker: port-level checks
// Handshake stability plus setup-blocking behavior after reset and writes.
// ----------------------------------------------------------------------------
module bpp_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              particle_valid,
	input wire logic              particle_ready,
	input wire logic              result_valid,
	input wire logic              result_ready,
	input bpp_pkg::result_t       result,
	input wire logic              cfg_valid,
	input wire logic              cfg_ready
);
	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result dropped or changed while stalled");

	// an offered particle stays offered until taken
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		particle_valid && !particle_ready |=> particle_valid)
		else $error("particle_valid dropped before acceptance");

	// cfg port never back-pressures
	a_cfg_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("cfg_ready low");

	// a write restarts the coefficient sequencer, which blocks particles
	a_cfg_block: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> !particle_ready)
		else $error("particle accepted during coefficient setup");

	// coefficients are derived right out of reset
	a_rst_block: assert property (@(posedge clk)
		!arst_n |=> !particle_ready)
		else $error("particle_ready high right after reset");

endmodule

bind boris_particle_push bpp_checker u_bpp_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.particle_valid (particle_valid),
	.particle_ready (particle_ready),
	.result_valid   (result_valid),
	.result_ready   (result_ready),
	.result         (result),
	.cfg_valid      (cfg_valid),
	.cfg_ready      (cfg_ready)
);
`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the Boris particle pusher
// Drives particles and register writes through valid/ready channels, keeps a
// fixed-point model of one Boris step and compares every result transaction
// field by field against the oldest predicted particle.
// ----------------------------------------------------------------------------
module testbench;

	localparam int    FB        = 16;
	localparam int    WATCHDOG  = 20000;
	localparam int    DRAIN_CYC = 200;
	localparam int    N_RANDOM  = 1130;
	localparam longint MAXW     = 64'sd2147483647;
	localparam longint MINW     = -64'sd2147483648;

	logic      clk;
	logic      arst_n;
	logic      particle_valid;
	logic      particle_ready;
	bpp_pkg::particle_t particle;
	logic      result_valid;
	logic      result_ready;
	bpp_pkg::result_t   result;
	logic      cfg_valid;
	logic      cfg_ready;
	logic [bpp_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [bpp_pkg::WORD_W-1:0]    cfg_data;

	boris_particle_push i_dut (
		.clk(clk), .arst_n(arst_n),
		.particle_valid(particle_valid), .particle_ready(particle_ready),
		.particle(particle),
		.result_valid(result_valid), .result_ready(result_ready), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// pending stimulus and predicted particles
	bpp_pkg::particle_t pending_particles[$];
	bpp_pkg::result_t   pushed_particles[$];

	// model copy of the register file
	longint field_e[3];
	longint field_b[3];
	longint step_dt;
	longint q_over_m;

	int  mismatches;
	int  idle_cycles;
	bit  idle_enable;      // random idling on both sides
	bit  hold_result;      // long receiver hold-off
	int  hold_count;

	// handshake flags sampled at the rising edge
	logic particle_ready_s;
	logic particle_fire;
	assign particle_fire = particle_valid && particle_ready;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ---------------- fixed-point model ----------------
	function automatic longint clampw(longint v);
		if (v > MAXW) return MAXW;
		if (v < MINW) return MINW;
		return v;
	endfunction

	function automatic longint add_sat(longint a, longint b);
		return clampw(a + b);
	endfunction

	function automatic longint sub_sat(longint a, longint b);
		return clampw(a - b);
	endfunction

	// round(a*b / 2^(FB+extra)), ties away from zero, saturated
	function automatic longint mul_rnd(longint a, longint b, int extra);
		logic signed [127:0] p;
		logic [127:0] mag;
		int sh;
		sh = FB + extra;
		p = 128'(signed'(a)) * 128'(signed'(b));
		mag = p[127] ? -p : p;
		mag = (mag + (128'd1 << (sh - 1))) >> sh;
		if (p[127]) begin
			if (mag > 128'd2147483648) return MINW;
			return -longint'(mag[63:0]);
		end
		if (mag > 128'd2147483647) return MAXW;
		return longint'(mag[63:0]);
	endfunction

	// 2.0 / den, rounded to nearest (den >= 1)
	function automatic longint two_div(longint den);
		logic [127:0] num;
		logic [127:0] quo;
		num = 128'd2 << (2 * FB + 1);
		quo = num / den;
		// one extra fraction bit then round
		quo = (quo + 1) >> 1;
		if (quo > 128'd2147483647) return MAXW;
		return longint'(quo[63:0]);
	endfunction

	function automatic bpp_pkg::result_t boris_step(bpp_pkg::particle_t pin);
		bpp_pkg::result_t r;
		longint v[3], p[3], kick[3], tv[3], sv[3], vm[3], vq[3], vn[3];
		longint tt, den, sf, vp;
		int j, k;
		v[0] = pin.vel_x_in; v[1] = pin.vel_y_in; v[2] = pin.vel_z_in;
		p[0] = pin.pos_x_in; p[1] = pin.pos_y_in; p[2] = pin.pos_z_in;
		for (int i = 0; i < 3; i++) begin
			kick[i] = mul_rnd(mul_rnd(q_over_m, field_e[i], 0), step_dt, 1);
			tv[i]   = mul_rnd(mul_rnd(q_over_m, field_b[i], 0), step_dt, 1);
			vm[i]   = add_sat(v[i], kick[i]);
		end
		tt = add_sat(add_sat(mul_rnd(tv[0], tv[0], 0), mul_rnd(tv[1], tv[1], 0)),
			mul_rnd(tv[2], tv[2], 0));
		den = add_sat(longint'(1) << FB, tt);
		if (den < 1) den = 1;
		sf = two_div(den);
		for (int i = 0; i < 3; i++) sv[i] = mul_rnd(sf, tv[i], 0);
		for (int i = 0; i < 3; i++) begin
			j = (i + 1) % 3; k = (i + 2) % 3;
			vq[i] = sub_sat(add_sat(vm[i], mul_rnd(vm[j], tv[k], 0)),
				mul_rnd(vm[k], tv[j], 0));
		end
		for (int i = 0; i < 3; i++) begin
			j = (i + 1) % 3; k = (i + 2) % 3;
			vp = sub_sat(add_sat(vm[i], mul_rnd(vq[j], sv[k], 0)),
				mul_rnd(vq[k], sv[j], 0));
			vn[i] = add_sat(vp, kick[i]);
		end
		r.vel_x_out = bpp_pkg::word_t'(vn[0]);
		r.vel_y_out = bpp_pkg::word_t'(vn[1]);
		r.vel_z_out = bpp_pkg::word_t'(vn[2]);
		r.pos_x_out = bpp_pkg::word_t'(add_sat(p[0], mul_rnd(vn[0], step_dt, 0)));
		r.pos_y_out = bpp_pkg::word_t'(add_sat(p[1], mul_rnd(vn[1], step_dt, 0)));
		r.pos_z_out = bpp_pkg::word_t'(add_sat(p[2], mul_rnd(vn[2], step_dt, 0)));
		return r;
	endfunction

	function automatic void model_write(logic [bpp_pkg::CFG_IDX_W-1:0] idx,
		logic [bpp_pkg::WORD_W-1:0] d);
		case (idx)
			bpp_pkg::REG_E_X:    field_e[0] = longint'(signed'(d));
			bpp_pkg::REG_E_Y:    field_e[1] = longint'(signed'(d));
			bpp_pkg::REG_E_Z:    field_e[2] = longint'(signed'(d));
			bpp_pkg::REG_B_X:    field_b[0] = longint'(signed'(d));
			bpp_pkg::REG_B_Y:    field_b[1] = longint'(signed'(d));
			bpp_pkg::REG_B_Z:    field_b[2] = longint'(signed'(d));
			bpp_pkg::REG_DT:     step_dt    = longint'(d[bpp_pkg::DT_W-1:0]);
			bpp_pkg::REG_CHARGE: q_over_m   = longint'(signed'(d));
			default: ;  // unknown index is ignored
		endcase
	endfunction

	// ---------------- driver ----------------
	// Particle valid stays up until accepted; a new one loads at the falling edge.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!particle_valid || particle_ready_s) begin
				if (pending_particles.size() > 0 &&
				    !(idle_enable && $urandom_range(99) < 32)) begin
					particle       <= pending_particles.pop_front();
					particle_valid <= 1'b1;
				end else begin
					particle_valid <= 1'b0;
				end
			end
			if (hold_result)
				result_ready <= 1'b0;
			else
				result_ready <= !(idle_enable && $urandom_range(99) < 32);
		end
	end

	// ---------------- monitor ----------------
	always @(posedge clk) begin
		bpp_pkg::result_t want;
		particle_ready_s <= particle_fire;
		if (particle_fire)
			pushed_particles.push_back(boris_step(particle));
		if (result_valid && result_ready) begin
			if (pushed_particles.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transaction %h", result);
			end else begin
				want = pushed_particles.pop_front();
				if (want != result) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch vel exp %h %h %h got %h %h %h",
							want.vel_x_out, want.vel_y_out, want.vel_z_out,
							result.vel_x_out, result.vel_y_out, result.vel_z_out);
						$display("         pos exp %h %h %h got %h %h %h",
							want.pos_x_out, want.pos_y_out, want.pos_z_out,
							result.pos_x_out, result.pos_y_out, result.pos_z_out);
					end
				end
			end
		end
		// watchdog on cycles without any transaction
		if (particle_fire || (result_valid && result_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("watchdog expired");
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// long receiver hold-off, counted in its own process
	always @(negedge clk) begin
		if (hold_count > 0) begin
			hold_count  <= hold_count - 1;
			hold_result <= 1'b1;
		end else begin
			hold_result <= 1'b0;
		end
	end

	// ---------------- stimulus helpers ----------------
	task automatic cfg_write(logic [bpp_pkg::CFG_IDX_W-1:0] idx,
		logic [bpp_pkg::WORD_W-1:0] d);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data  <= d;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		model_write(idx, d);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		while (pending_particles.size() > 0 || particle_valid ||
		       pushed_particles.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic bpp_pkg::word_t rand_word();
		case ($urandom_range(5))
			0: return bpp_pkg::WORD_MAX;
			1: return bpp_pkg::WORD_MIN;
			2: return bpp_pkg::word_t'($urandom_range(8) * 32'sh10000) *
				($urandom_range(1) ? 1 : -1);
			3: return bpp_pkg::word_t'(signed'($urandom_range(32'h0003ffff))) - 32'sh20000;
			default: return bpp_pkg::word_t'($urandom);
		endcase
	endfunction

	function automatic bpp_pkg::particle_t rand_particle();
		bpp_pkg::particle_t pp;
		pp.vel_x_in = rand_word(); pp.vel_y_in = rand_word(); pp.vel_z_in = rand_word();
		pp.pos_x_in = rand_word(); pp.pos_y_in = rand_word(); pp.pos_z_in = rand_word();
		return pp;
	endfunction

	task automatic cfg_random(bit extreme);
		for (int i = 0; i <= bpp_pkg::REG_CHARGE + 1; i++) begin
			logic [bpp_pkg::WORD_W-1:0] d;
			if (extreme)
				d = $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
			else
				d = $urandom_range(1) ? $urandom : 32'($urandom_range(32'h3ffff)) - 32'h20000;
			cfg_write(bpp_pkg::CFG_IDX_W'(i), d);
		end
	endtask

	// ---------------- main sequence ----------------
	initial begin
		bpp_pkg::particle_t pd;
		arst_n = 1'b0;
		particle_valid = 1'b0; particle = '0;
		result_ready = 1'b0; cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
		particle_ready_s = 1'b0;
		mismatches = 0; idle_cycles = 0;
		idle_enable = 1'b0; hold_result = 1'b0; hold_count = 0;
		field_e = '{0, 0, 0}; field_b = '{0, 0, -65536};
		step_dt = 655; q_over_m = -65536;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset fields, particle extremes and sign patterns
		pending_particles.push_back('0);
		pd = '{bpp_pkg::WORD_MAX, bpp_pkg::WORD_MAX, bpp_pkg::WORD_MAX,
			bpp_pkg::WORD_MAX, bpp_pkg::WORD_MAX, bpp_pkg::WORD_MAX};
		pending_particles.push_back(pd);
		pd = '{bpp_pkg::WORD_MIN, bpp_pkg::WORD_MIN, bpp_pkg::WORD_MIN,
			bpp_pkg::WORD_MIN, bpp_pkg::WORD_MIN, bpp_pkg::WORD_MIN};
		pending_particles.push_back(pd);
		pd = '{32'sh10000, 32'sh0, -32'sh10000, 32'sh7fff0000, -32'sh7fff0000, 32'sh1};
		pending_particles.push_back(pd);
		drain();
		// strong fields: |t| large, saturation everywhere
		cfg_write(bpp_pkg::REG_DT, 32'h7fffffff);
		cfg_write(bpp_pkg::REG_B_X, 32'h7fffffff);
		cfg_write(bpp_pkg::REG_E_Y, 32'h80000000);
		for (int i = 0; i < 6; i++) pending_particles.push_back(rand_particle());
		pd = '{bpp_pkg::WORD_MAX, bpp_pkg::WORD_MIN, bpp_pkg::WORD_MAX,
			bpp_pkg::WORD_MIN, bpp_pkg::WORD_MAX, bpp_pkg::WORD_MIN};
		pending_particles.push_back(pd);
		drain();
		cfg_write(bpp_pkg::REG_DT, 32'h0);
		cfg_write(bpp_pkg::REG_CHARGE, 32'h0);
		for (int i = 0; i < 4; i++) pending_particles.push_back(rand_particle());
		drain();
		cfg_write(bpp_pkg::REG_CHARGE, 32'h7fffffff);
		cfg_write(bpp_pkg::REG_DT, 32'hffffffff);   // top bit dropped by a 31-bit register
		cfg_write(4'd12, 32'h12345678);             // unknown index
		for (int i = 0; i < 4; i++) pending_particles.push_back(rand_particle());
		drain();

		// random phases with changing settings
		idle_enable = 1'b1;
		for (int ph = 0; ph < 10; ph++) begin
			if (ph == 3)      cfg_random(1'b1);
			else if (ph != 0) cfg_random(1'b0);
			idle_enable = (ph != 5);
			if (ph == 2) hold_count = 300;
			for (int i = 0; i < N_RANDOM / 10; i++)
				pending_particles.push_back(rand_particle());
			drain();
		end

		repeat (DRAIN_CYC) @(posedge clk);
		if (mismatches == 0 && pushed_particles.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

>>> sim.f
src/bpp_pkg.sv
src/bpp_setup.sv
src/bpp_front.sv
src/bpp_queue.sv
src/bpp_back.sv
src/boris_particle_push.sv
src/bpp_checker.sv
tb/sv/testbench.sv
